### hw/rtl/fgd_pkg.sv
package fgd_pkg;

    typedef enum logic [1:0]
    {
        ST_OK,
        ST_FLEXRAM_UNSUP,
        ST_BANK_INVALID,
        ST_BANK_EMPTY
    } status_t;

    typedef enum logic [1:0]
    {
        CLS_NONE,
        CLS_PFLASH,
        CLS_NVM
    } class_t;

    localparam logic [1:0]  GRAN_MAX           = 2'd3;
    localparam logic [3:0]  SIZE_CODE_ALL_ONES = 4'hf;
    localparam logic [15:0] NVM_CODE_MASK      = 16'h0a88;
    localparam logic [15:0] PF_CODE_MASK       = 16'h2aa8;
    localparam logic [4:0]  SIZE_EXP_BASE      = 5'd14;
    localparam logic [3:0]  EE_CODE_MAX        = 4'd9;
    localparam logic [3:0]  EE_EXP_TOP         = 4'd14;

    localparam logic [19:0] NV_BYTES_BIG = 20'(512 << 10);
    localparam logic [19:0] NV_BYTES_STD = 20'(256 << 10);
    localparam logic [20:0] PF_SIZE_BIG  = 21'(1024 << 10);
    localparam logic [20:0] PF_SIZE_MID  = 21'(512 << 10);
    localparam logic [20:0] PF_SIZE_STD  = 21'(256 << 10);

    localparam logic [28:0] NVM_BASE       = 29'h1000_0000;
    localparam logic [3:0]  SEC_SHIFT_BASE = 4'd10;

    localparam logic [1:0] PF_SEC_OFF [0:3] = '{2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] NV_SEC_OFF [0:3] = '{2'd0, 2'd0, 2'd1, 2'd2};

    typedef struct packed
    {
        logic [1:0]  gran;
        logic        no_nvm;
        logic [3:0]  bank;
        logic [20:0] pf_size;
        logic [19:0] nv_bytes;
        logic [14:0] ee_size;
    } dec_t;

    typedef struct packed
    {
        logic [1:0]  gran;
        logic [20:0] pf_size;
        logic [19:0] nv_bytes;
        logic [14:0] ee_size;
        status_t     status;
        class_t      cls;
        logic [20:0] bsize;
        logic [1:0]  sec_off;
        logic [1:0]  idx;
        logic [15:0] prot;
    } bank_t;

    typedef struct packed
    {
        status_t     status;
        class_t      bank_class;
        logic [20:0] bank_bytes;
        logic [28:0] bank_base;
        logic [12:0] sector_bytes;
        logic [10:0] sector_count;
        logic [15:0] protect_unit_bytes;
        logic [14:0] flexram_bytes;
        logic [1:0]  granularity_code;
        logic [20:0] pflash_total_bytes;
        logic [19:0] nvm_total_bytes;
    } rsp_t;

    function automatic logic [19:0] nv_bytes_f(input logic [3:0] code, input logic [1:0] gran);
        logic [19:0] size;
        size = '0;
        if (code == SIZE_CODE_ALL_ONES)
        begin
            size = (gran == GRAN_MAX) ? NV_BYTES_BIG : NV_BYTES_STD;
        end
        else if (NVM_CODE_MASK[code])
        begin
            size = 20'(1) << (SIZE_EXP_BASE + 5'(code[3:1]));
        end
        return size;
    endfunction

    function automatic logic [20:0] pf_size_f(input logic [3:0] code, input logic [1:0] gran,
                                              input logic no_nvm);
        logic [20:0] size;
        size = '0;
        if (code == SIZE_CODE_ALL_ONES)
        begin
            if (gran == GRAN_MAX)
                size = PF_SIZE_BIG;
            else if (no_nvm)
                size = PF_SIZE_MID;
            else
                size = PF_SIZE_STD;
        end
        else if (PF_CODE_MASK[code])
        begin
            size = 21'(1) << (SIZE_EXP_BASE + 5'(code[3:1]));
        end
        return size;
    endfunction

    function automatic logic [14:0] ee_size_f(input logic [3:0] code);
        logic [14:0] size;
        size = '0;
        if (code <= EE_CODE_MAX)
        begin
            size = 15'(1) << (EE_EXP_TOP - code);
        end
        return size;
    endfunction

endpackage

### hw/rtl/fgd_req_if.sv
interface fgd_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] sdid_word;
    logic [31:0] fcfg1_word;
    logic [31:0] fcfg2_word;
    logic [3:0]  bank_index;

    modport source
    (
        output valid, sdid_word, fcfg1_word, fcfg2_word, bank_index,
        input  ready
    );

    modport sink
    (
        input  valid, sdid_word, fcfg1_word, fcfg2_word, bank_index,
        output ready
    );
endinterface

### hw/rtl/fgd_rsp_if.sv
interface fgd_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  bank_class;
    logic [20:0] bank_bytes;
    logic [28:0] bank_base;
    logic [12:0] sector_bytes;
    logic [10:0] sector_count;
    logic [15:0] protect_unit_bytes;
    logic [14:0] flexram_bytes;
    logic [1:0]  granularity_code;
    logic [20:0] pflash_total_bytes;
    logic [19:0] nvm_total_bytes;

    modport source
    (
        output valid, status, bank_class, bank_bytes, bank_base, sector_bytes, sector_count,
               protect_unit_bytes, flexram_bytes, granularity_code, pflash_total_bytes,
               nvm_total_bytes,
        input  ready
    );

    modport sink
    (
        input  valid, status, bank_class, bank_bytes, bank_base, sector_bytes, sector_count,
               protect_unit_bytes, flexram_bytes, granularity_code, pflash_total_bytes,
               nvm_total_bytes,
        output ready
    );
endinterface

### hw/rtl/fgd_decode.sv
module fgd_decode
    import fgd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_out,
    input  logic [31:0] sdid_word,
    input  logic [31:0] fcfg1_word,
    input  logic [31:0] fcfg2_word,
    input  logic [3:0]  bank_index,
    output logic        valid_out,
    input  logic        ready_in,
    output dec_t        data_out
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;

    always_comb
    begin
        data_next.gran   = sdid_word[8:7];
        data_next.no_nvm = fcfg2_word[23];
        data_next.bank   = bank_index;
        data_next.pf_size = pf_size_f(fcfg1_word[27:24], sdid_word[8:7], fcfg2_word[23]);
        if (fcfg2_word[23])
        begin
            data_next.nv_bytes = '0;
            data_next.ee_size  = '0;
        end
        else
        begin
            data_next.nv_bytes = nv_bytes_f(fcfg1_word[31:28], sdid_word[8:7]);
            data_next.ee_size  = ee_size_f(fcfg1_word[19:16]);
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### hw/rtl/fgd_bank.sv
module fgd_bank
    import fgd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    output logic  ready_out,
    input  dec_t  data_in,
    output logic  valid_out,
    input  logic  ready_in,
    output bank_t data_out
);

    logic       valid_reg;
    bank_t      data_reg;
    bank_t      data_next;
    logic [1:0] blk_shift;
    logic [1:0] npf_shift;
    logic [1:0] nnv_shift;
    logic [2:0] npf;
    logic [2:0] nblocks;
    logic [3:0] nv_ord;

    always_comb
    begin
        blk_shift = (data_in.gran == GRAN_MAX) ? 2'd2 : 2'd1;
        npf_shift = data_in.no_nvm ? blk_shift : blk_shift - 2'd1;
        nnv_shift = blk_shift - 2'd1;
        npf       = 3'(1) << npf_shift;
        nblocks   = 3'(1) << blk_shift;
        nv_ord    = data_in.bank - {1'b0, npf};

        data_next.gran     = data_in.gran;
        data_next.pf_size  = data_in.pf_size;
        data_next.nv_bytes = data_in.nv_bytes;
        data_next.ee_size  = data_in.ee_size;
        data_next.status   = ST_OK;
        data_next.cls      = CLS_NONE;
        data_next.bsize    = '0;
        data_next.sec_off  = '0;
        data_next.idx      = '0;
        data_next.prot     = '0;

        if (data_in.bank < {1'b0, npf})
        begin
            data_next.cls     = CLS_PFLASH;
            data_next.bsize   = data_in.pf_size >> npf_shift;
            data_next.idx     = data_in.bank[1:0];
            data_next.sec_off = PF_SEC_OFF[data_in.gran];
            data_next.prot    = data_in.pf_size[20:5];
        end
        else if (data_in.bank < {1'b0, nblocks})
        begin
            data_next.cls     = CLS_NVM;
            data_next.bsize   = {1'b0, data_in.nv_bytes} >> nnv_shift;
            data_next.idx     = nv_ord[1:0];
            data_next.sec_off = NV_SEC_OFF[data_in.gran];
        end
        else if (data_in.bank == {1'b0, nblocks})
        begin
            data_next.status = ST_FLEXRAM_UNSUP;
        end
        else
        begin
            data_next.status = ST_BANK_INVALID;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### hw/rtl/fgd_place.sv
module fgd_place
    import fgd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  valid_in,
    output logic  ready_out,
    input  bank_t data_in,
    output logic  valid_out,
    input  logic  ready_in,
    output rsp_t  data_out
);

    logic        valid_reg;
    rsp_t        data_reg;
    rsp_t        data_next;
    logic [3:0]  sec_shift;
    logic [20:0] cnt_full;
    logic [22:0] offset;

    always_comb
    begin
        sec_shift = SEC_SHIFT_BASE + 4'(data_in.sec_off);
        cnt_full  = data_in.bsize >> sec_shift;

        case (data_in.idx)
            2'd0:    offset = '0;
            2'd1:    offset = {2'b0, data_in.bsize};
            2'd2:    offset = {1'b0, data_in.bsize, 1'b0};
            default: offset = {2'b0, data_in.bsize} + {1'b0, data_in.bsize, 1'b0};
        endcase

        data_next.status             = data_in.status;
        data_next.bank_class         = data_in.cls;
        data_next.bank_bytes         = data_in.bsize;
        data_next.bank_base          = '0;
        data_next.sector_bytes       = '0;
        data_next.sector_count       = '0;
        data_next.protect_unit_bytes = data_in.prot;
        data_next.flexram_bytes      = data_in.ee_size;
        data_next.granularity_code   = data_in.gran;
        data_next.pflash_total_bytes = data_in.pf_size;
        data_next.nvm_total_bytes    = data_in.nv_bytes;

        if (data_in.cls != CLS_NONE)
        begin
            data_next.sector_bytes = 13'(1) << sec_shift;
            data_next.sector_count = cnt_full[10:0];
            data_next.bank_base    = (data_in.cls == CLS_NVM) ? NVM_BASE + 29'(offset)
                                                              : 29'(offset);
            if (cnt_full == '0)
                data_next.status = ST_BANK_EMPTY;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_out)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

### hw/rtl/flash_geometry_decoder.sv
// Channel | Dir | Payload
// req     | in  | sdid_word, fcfg1_word, fcfg2_word, bank_index
// rsp     | out | status, class, bank size/base, sector size/count, totals
//
// Three register stages (decode, bank select, placement).
// One request per cycle sustained while rsp.ready is high; each stage holds its own valid bit.
// rst_n clears the valid bits only; payload registers are not reset.
// A stall on rsp holds each full stage and backs up to req.ready.
module flash_geometry_decoder
    import fgd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    fgd_req_if.sink  req,
    fgd_rsp_if.source rsp
);

    logic  s1_valid;
    logic  s1_ready;
    dec_t  s1_data;
    logic  s2_valid;
    logic  s2_ready;
    bank_t s2_data;
    rsp_t  s3_data;

    fgd_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (req.valid),
        .ready_out  (req.ready),
        .sdid_word  (req.sdid_word),
        .fcfg1_word (req.fcfg1_word),
        .fcfg2_word (req.fcfg2_word),
        .bank_index (req.bank_index),
        .valid_out  (s1_valid),
        .ready_in   (s1_ready),
        .data_out   (s1_data)
    );

    fgd_bank u_bank
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid),
        .ready_out (s1_ready),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .ready_in  (s2_ready),
        .data_out  (s2_data)
    );

    fgd_place u_place
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s2_valid),
        .ready_out (s2_ready),
        .data_in   (s2_data),
        .valid_out (rsp.valid),
        .ready_in  (rsp.ready),
        .data_out  (s3_data)
    );

    assign rsp.status             = s3_data.status;
    assign rsp.bank_class         = s3_data.bank_class;
    assign rsp.bank_bytes         = s3_data.bank_bytes;
    assign rsp.bank_base          = s3_data.bank_base;
    assign rsp.sector_bytes       = s3_data.sector_bytes;
    assign rsp.sector_count       = s3_data.sector_count;
    assign rsp.protect_unit_bytes = s3_data.protect_unit_bytes;
    assign rsp.flexram_bytes      = s3_data.flexram_bytes;
    assign rsp.granularity_code   = s3_data.granularity_code;
    assign rsp.pflash_total_bytes = s3_data.pflash_total_bytes;
    assign rsp.nvm_total_bytes    = s3_data.nvm_total_bytes;

`ifndef NO_ASSERTIONS
    a_ok_has_sectors: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_OK |-> rsp.sector_count != '0)
        else $error("ok response with no sectors");

    a_bad_bank_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FLEXRAM_UNSUP || rsp.status == ST_BANK_INVALID)
        |-> rsp.bank_class == CLS_NONE && rsp.bank_bytes == '0 && rsp.bank_base == '0)
        else $error("rejected bank carries geometry");

    a_pf_protect: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bank_class == CLS_PFLASH
        |-> rsp.protect_unit_bytes == rsp.pflash_total_bytes[20:5])
        else $error("protection unit does not match program flash total");

    a_nvm_base: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.bank_class == CLS_NVM |-> rsp.bank_base[28] && rsp.protect_unit_bytes == '0)
        else $error("nvm bank placed below nvm base");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
        else $error("decode stage lost a stalled request");
`endif

endmodule
